/* design/mlc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mlc_pkg;

	// table geometry
	localparam int TABLE_SLOTS = 16;
	localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// stream widths
	localparam int IN_TDATA_W  = 88;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_TUSER_W = 1;

	typedef enum logic [1:0] {
		CMD_STORE      = 2'd0,
		CMD_GET_ID     = 2'd1,
		CMD_GET_LATEST = 2'd2,
		CMD_COUNT      = 2'd3
	} cmd_t;

	// classified operation; OP_NONE is any command while the table is off
	typedef enum logic [2:0] {
		OP_NONE,
		OP_STORE,
		OP_GET_ID,
		OP_GET_LATEST,
		OP_COUNT
	} op_t;

	typedef struct packed {
		logic [7:0] dest_component;
		logic [7:0] dest_system;
		logic [7:0] source_component;
		logic [7:0] source_system;
	} hdr_t;

	// key in the low bits, same layout as the input tdata
	typedef struct packed {
		logic [31:0] stamp;
		hdr_t        hdr;
		logic [23:0] key;
	} entry_t;

	typedef struct packed {
		op_t    op;
		entry_t ent;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [4:0]  occupied;
		logic        updated;
		entry_t      ent;
		logic [3:0]  slot;
	} res_t;

	localparam int RES_DATA_W = $bits(res_t) - 1;
	localparam int OUT_PAD_W  = OUT_TDATA_W - RES_DATA_W;

endpackage

`default_nettype wire

/* design/mlc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* design/mlc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mlc_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic [mlc_pkg::IN_TUSER_W-1:0]    s_tuser,
	output logic                              q_valid,
	output mlc_pkg::item_t                    q_item,
	input  logic                              q_pop
);

	import mlc_pkg::*;

	logic               enable_q;
	item_t              fifo_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] fill_q;
	item_t              item_d;
	cmd_t               cmd;
	logic               push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	// classify
	always_comb begin
		cmd        = cmd_t'(s_tuser);
		item_d.ent = entry_t'(s_tdata);
		item_d.op  = OP_NONE;
		if (enable_q) begin
			unique case (cmd)
				CMD_STORE:      item_d.op = OP_STORE;
				CMD_GET_ID:     item_d.op = OP_GET_ID;
				CMD_GET_LATEST: item_d.op = OP_GET_LATEST;
				CMD_COUNT:      item_d.op = OP_COUNT;
				default:        item_d.op = OP_NONE;
			endcase
		end
	end

	assign s_tready = (fill_q != Q_CNT_W'(Q_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (fill_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (q_pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/mlc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mlc_pkg::item_t q_item,
	output logic           q_pop,
	output logic           m_valid,
	input  logic           m_ready,
	output mlc_pkg::res_t  m_res
);

	import mlc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);

	state_t                   state_q;
	item_t                    item_q;
	logic [TABLE_SLOTS-1:0]   slot_valid_q;
	logic [TABLE_SLOTS-1:0]   slot_updated_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [SLOT_W-1:0]        rd_idx_q;
	logic                     issue_q;
	logic                     cmp_live_s1;
	logic [SLOT_W-1:0]        cmp_idx_s1;
	logic                     hit_q;
	logic [SLOT_W-1:0]        hit_idx_q;
	entry_t                   ent_q;
	logic                     m_valid_q;
	res_t                     res_q;

	entry_t                   rd_ent;
	logic [$bits(entry_t)-1:0] rd_word;
	logic                     slot_ok;
	logic [31:0]              best;
	logic                     take;
	logic                     free_any;
	logic [SLOT_W-1:0]        free_idx;
	logic                     wr_req;
	logic                     alloc;
	logic [SLOT_W-1:0]        wr_slot;
	logic [CNT_W-1:0]         cnt_next;
	res_t                     res_d;
	logic                     out_free;
	logic                     fin_go;
	logic                     is_scan_op;

	mlc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (fin_go && wr_req),
		.wr_addr (wr_slot),
		.wr_data (item_q.ent),
		.rd_en   (issue_q),
		.rd_addr (rd_idx_q),
		.rd_data (rd_word)
	);

	assign rd_ent = entry_t'(rd_word);

	// compare stage: key match for store / get, newest nonzero stamp for latest
	always_comb begin
		slot_ok = slot_valid_q[cmp_idx_s1];
		best    = hit_q ? ent_q.stamp : 32'd0;
		if (item_q.op == OP_GET_LATEST) begin
			take = cmp_live_s1 && slot_ok && (rd_ent.stamp > best);
		end else begin
			take = cmp_live_s1 && slot_ok && !hit_q && (rd_ent.key == item_q.ent.key);
		end
	end

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int k = TABLE_SLOTS - 1; k >= 0; k--) begin
			if (!slot_valid_q[k]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(k);
			end
		end
	end

	// result of the finished command
	always_comb begin
		res_d   = '0;
		wr_req  = 1'b0;
		alloc   = 1'b0;
		wr_slot = hit_idx_q;
		case (item_q.op)
			OP_STORE: begin
				if (hit_q) begin
					wr_req = 1'b1;
				end else if (free_any) begin
					wr_req  = 1'b1;
					alloc   = 1'b1;
					wr_slot = free_idx;
				end
				if (wr_req) begin
					res_d.found   = 1'b1;
					res_d.slot    = 4'(wr_slot);
					res_d.ent     = item_q.ent;
					res_d.updated = 1'b1;
				end
			end
			OP_GET_ID, OP_GET_LATEST: begin
				if (hit_q) begin
					res_d.found   = 1'b1;
					res_d.slot    = 4'(hit_idx_q);
					res_d.ent     = ent_q;
					res_d.updated = slot_updated_q[hit_idx_q];
				end
			end
			default: ;
		endcase
		cnt_next = cnt_q + {{(CNT_W - 1){1'b0}}, alloc};
		if (item_q.op != OP_NONE) begin
			res_d.occupied = 5'(cnt_next);
		end
	end

	assign out_free   = !m_valid_q || m_ready;
	assign fin_go     = (state_q == ST_FIN) && out_free;
	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign is_scan_op = (q_item.op == OP_STORE) || (q_item.op == OP_GET_ID) ||
	                    (q_item.op == OP_GET_LATEST);

	// payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (take) begin
			ent_q     <= rd_ent;
			hit_idx_q <= cmp_idx_s1;
		end
		if (fin_go) begin
			res_q <= res_d;
		end
		cmp_idx_s1 <= rd_idx_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			slot_valid_q   <= '0;
			slot_updated_q <= '0;
			cnt_q          <= '0;
			rd_idx_q       <= '0;
			issue_q        <= 1'b0;
			cmp_live_s1    <= 1'b0;
			hit_q          <= 1'b0;
			m_valid_q      <= 1'b0;
		end else begin
			cmp_live_s1 <= issue_q;
			if (take) begin
				hit_q <= 1'b1;
			end
			if (issue_q) begin
				if (rd_idx_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			if (fin_go) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						hit_q <= 1'b0;
						if (is_scan_op) begin
							rd_idx_q <= '0;
							issue_q  <= 1'b1;
							state_q  <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (cmp_live_s1 && (cmp_idx_s1 == LAST_IDX)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (wr_req) begin
							slot_valid_q[wr_slot]   <= 1'b1;
							slot_updated_q[wr_slot] <= 1'b1;
						end
						cnt_q   <= cnt_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_valid = m_valid_q;
	assign m_res   = res_q;

endmodule

`default_nettype wire

/* design/message_id_latest_cache_unit.sv */
// Latest-message cache: one entry per message id, TABLE_SLOTS slots.
//
// Channels:
//   cfg    : one-bit table enable, written when cfg_valid && cfg_ready
//            (always ready). Write it only while the block is idle.
//   s_*    : command transfers. tuser = command (store, get by id,
//            get latest, count), tdata = id, header ids and timestamp.
//   m_*    : one result transfer per command, tuser = found flag.
// Operation:
//   A store, get by id or get latest reads the slot RAM one slot per
//   cycle and scans all TABLE_SLOTS slots before its result goes to the
//   output register. Count and any command while the table is disabled
//   skip the scan. The slot RAM read port sets the command rate.
//   A two-deep command queue takes new commands while one is scanned
//   and while a result waits at the output.
// Reset: table empty (all slots free, updated marks clear), table disabled,
//   queue and output empty. No clearing pass is needed.
// Stall: with m_tready low the result holds in the output register; the
//   back end finishes its scan and waits, the queue fills, then s_tready
//   drops.
`timescale 1ns / 1ps
`default_nettype none

module message_id_latest_cache_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data,
	// command stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [23:0] message_id, [31:24] source_system, [39:32] source_component,
	// [47:40] dest_system, [55:48] dest_component, [87:56] arrival_time
	input  logic [mlc_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [1:0] command
	input  logic [mlc_pkg::IN_TUSER_W-1:0]    s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [3:0] slot, [27:4] entry_message_id, [35:28] entry_source_system,
	// [43:36] entry_source_component, [51:44] entry_dest_system,
	// [59:52] entry_dest_component, [91:60] entry_time, [92] entry_updated,
	// [97:93] occupied_count, [103:98] zero
	output logic [mlc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] found
	output logic [mlc_pkg::OUT_TUSER_W-1:0]   m_tuser
);

	import mlc_pkg::*;

	logic  q_valid;
	item_t q_item;
	logic  q_pop;
	res_t  res;

	// front: config register, classification, command queue
	mlc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// back: slot scan, table update, output register
	mlc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_res   (res)
	);

	// everything but the found flag goes to tdata, zero padded to bytes
	assign m_tdata = {{OUT_PAD_W{1'b0}}, res.occupied, res.updated, res.ent, res.slot};
	assign m_tuser = res.found;

endmodule

`default_nettype wire

/* design/mlc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mlc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [mlc_pkg::OUT_TUSER_W-1:0] m_tuser
);

	import mlc_pkg::*;

	// queue + one in the back end + one in the output register
	localparam int PEND_MAX = Q_DEPTH + 2;
	localparam int PEND_W   = $clog2(PEND_MAX + 1);

	logic [PEND_W-1:0] pend_q;
	logic              s_xfer;
	logic              m_xfer;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (s_xfer && !m_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (m_xfer && !s_xfer) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[92:0] == '0)
		else $error("entry fields nonzero on a miss");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != '0)
		else $error("result without a pending command");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == PEND_W'(PEND_MAX) |-> !s_tready)
		else $error("command accepted beyond capacity");

endmodule

bind message_id_latest_cache_unit mlc_checker u_mlc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* test/message_id_latest_cache_unit_test.sv */
`timescale 1ns / 1ps

module message_id_latest_cache_unit_test;

	import mlc_pkg::*;

	localparam int SLOTS     = 16;
	localparam int POOL_SIZE = 20;

	// one result transfer, split into its fields
	typedef struct packed {
		logic        found;
		logic [3:0]  slot;
		logic [23:0] msg_id;
		logic [7:0]  src_sys;
		logic [7:0]  src_comp;
		logic [7:0]  dst_sys;
		logic [7:0]  dst_comp;
		logic [31:0] stamp;
		logic        updated;
		logic [4:0]  occupied;
	} cache_reply_t;

	// Shadow copy of the message table plus the replies still owed by the block.
	class cache_scoreboard;
		bit           enabled;
		bit           used[SLOTS];
		bit [23:0]    key[SLOTS];
		bit [31:0]    hdr[SLOTS];
		bit [31:0]    stamp[SLOTS];
		bit           updated[SLOTS];
		cache_reply_t replies[$];
		int           errors;

		function new();
			enabled = 0;
			errors  = 0;
			foreach (used[k]) begin
				used[k]    = 0;
				key[k]     = '0;
				hdr[k]     = '0;
				stamp[k]   = '0;
				updated[k] = 0;
			end
		endfunction

		function void set_enable(bit v);
			enabled = v;
		endfunction

		function int occupied();
			int n;
			n = 0;
			if (enabled)
				foreach (used[k]) if (used[k]) n++;
			return n;
		endfunction

		function int find_id(bit [23:0] id);
			for (int k = 0; k < SLOTS; k++)
				if (used[k] && key[k] == id) return k;
			return -1;
		endfunction

		// apply one accepted command to the shadow table and queue its reply
		function void note_command(cmd_t cmd, bit [23:0] id, bit [31:0] h, bit [31:0] t);
			cache_reply_t want;
			int           hit;
			bit [31:0]    best;
			want = '0;
			hit  = -1;
			if (enabled) begin
				case (cmd)
					CMD_STORE: begin
						hit = find_id(id);
						if (hit < 0)
							for (int k = 0; k < SLOTS; k++)
								if (!used[k]) begin
									hit = k;
									break;
								end
						if (hit >= 0) begin
							used[hit]    = 1;
							key[hit]     = id;
							hdr[hit]     = h;
							stamp[hit]   = t;
							updated[hit] = 1;
						end
					end
					CMD_GET_ID: hit = find_id(id);
					CMD_GET_LATEST: begin
						// strictly greater, so the lowest slot wins a tie and zero never wins
						best = 0;
						for (int k = 0; k < SLOTS; k++)
							if (used[k] && stamp[k] > best) begin
								best = stamp[k];
								hit  = k;
							end
					end
					default: ;
				endcase
			end
			if (hit >= 0) begin
				want.found    = 1;
				want.slot     = hit[3:0];
				want.msg_id   = key[hit];
				want.src_sys  = hdr[hit][7:0];
				want.src_comp = hdr[hit][15:8];
				want.dst_sys  = hdr[hit][23:16];
				want.dst_comp = hdr[hit][31:24];
				want.stamp    = stamp[hit];
				want.updated  = updated[hit];
			end
			want.occupied = occupied();
			replies.push_back(want);
		endfunction

		task report(string msg);
			$display("%0t: %s", $time, msg);
			errors++;
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s is %h, expected %h", name, got, want));
		endtask

		task check_reply(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
			cache_reply_t want;
			if (replies.size() == 0) begin
				report("result transfer with no command outstanding");
				return;
			end
			want = replies.pop_front();
			check_field("found", user[0], want.found);
			check_field("slot", data[3:0], want.slot);
			check_field("entry_message_id", data[27:4], want.msg_id);
			check_field("entry_source_system", data[35:28], want.src_sys);
			check_field("entry_source_component", data[43:36], want.src_comp);
			check_field("entry_dest_system", data[51:44], want.dst_sys);
			check_field("entry_dest_component", data[59:52], want.dst_comp);
			check_field("entry_time", data[91:60], want.stamp);
			check_field("entry_updated", data[92], want.updated);
			check_field("occupied_count", data[97:93], want.occupied);
			check_field("tdata padding", data[103:98], '0);
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // id, source sys/comp, dest sys/comp, arrival time
	logic [IN_TUSER_W-1:0]  s_tuser;   // command
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // slot, entry fields, updated, count, pad
	logic [OUT_TUSER_W-1:0] m_tuser;   // found

	cache_scoreboard sb;
	bit              calm;             // when set, neither side idles or stalls
	bit [23:0]       id_pool[POOL_SIZE];

	message_id_latest_cache_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// 8 ns clock
	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Hard stop. A correct run needs under a third of this even with
	// every transfer hitting the longest sender gap and receiver stall.
	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Every accepted result transfer is checked against the oldest reply owed.
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_reply(m_tdata, m_tuser);

	// Sender gap: mostly back to back or short, now and then long.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function int pick_stall();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	// Receiver: alternating ready and stall stretches, changed at the falling edge.
	initial begin
		int hold;
		bit level;
		hold = 0;
		level = 0;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm) begin
				m_tready = 1;
				hold = 0;
			end else begin
				if (hold == 0) begin
					level = !m_tready;
					hold = level ? $urandom_range(1, 12) : pick_stall();
				end
				m_tready = level;
				hold--;
			end
		end
	end

	// One command transfer. Valid stays up after acceptance; whatever comes
	// next at the following falling edge either replaces or drops it.
	task send_command(cmd_t cmd, bit [23:0] id, bit [31:0] h, bit [31:0] t);
		@(negedge clk);
		s_tvalid = 1;
		s_tuser  = cmd;
		s_tdata  = {t, h, id};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, id, h, t);
	endtask

	task issue(cmd_t cmd, bit [23:0] id, bit [31:0] h, bit [31:0] t);
		int gap;
		send_command(cmd, id, h, t);
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 0;
		end
	endtask

	task wait_drained();
		@(negedge clk);
		s_tvalid = 0;
		while (sb.replies.size() != 0) @(posedge clk);
	endtask

	// Enable is only written with no command in flight.
	task write_enable(bit v);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_enable(v);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function bit [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return $urandom;
	endfunction

	// zero times and a few repeated values make ties for get latest
	function bit [31:0] pick_time();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return 32'h0;
		if (r < 4) begin
			case ($urandom_range(0, 3))
				0: return 32'h1;
				1: return 32'h2;
				2: return 32'hFFFF_FFFE;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	// Most ids come from a pool a bit larger than the table, so stores hit,
	// the table fills, and later new ids find it full.
	task random_command();
		cmd_t      cmd;
		bit [23:0] id;
		int        r;
		r = $urandom_range(0, 99);
		if (r < 45) cmd = CMD_STORE;
		else if (r < 70) cmd = CMD_GET_ID;
		else if (r < 85) cmd = CMD_GET_LATEST;
		else cmd = CMD_COUNT;
		if ($urandom_range(0, 9) == 0) id = $urandom;
		else id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		issue(cmd, id, {pick_byte(), pick_byte(), pick_byte(), pick_byte()}, pick_time());
	endtask

	task random_phase(bit en, bit quiet, int count);
		write_enable(en);
		calm = quiet;
		repeat (count) random_command();
	endtask

	initial begin
		sb = new();
		calm = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		id_pool[0] = 24'h000000;
		id_pool[1] = 24'hFFFFFF;
		id_pool[2] = 24'h123456;
		for (int k = 3; k < POOL_SIZE; k++) id_pool[k] = $urandom;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// disabled table: stores are dropped, nothing is found, count reads zero
		write_enable(0);
		issue(CMD_STORE, 24'h00ABCD, 32'h0403_0201, 32'h0000_0100);
		issue(CMD_GET_ID, 24'h00ABCD, '0, '0);
		issue(CMD_GET_LATEST, '0, '0, '0);
		issue(CMD_COUNT, '0, '0, '0);

		write_enable(1);
		issue(CMD_GET_LATEST, '0, '0, '0);                        // empty table
		issue(CMD_COUNT, '0, '0, '0);
		issue(CMD_STORE, 24'h000000, 32'h0000_0000, 32'h0);       // all-zero fields
		issue(CMD_GET_LATEST, '0, '0, '0);                        // only a zero time held
		issue(CMD_STORE, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(CMD_STORE, 24'h123456, 32'h5A5A_A5A5, 32'hFFFF_FFFF);
		issue(CMD_GET_LATEST, '0, '0, '0);                        // tie: lower slot wins
		issue(CMD_GET_ID, 24'hFFFFFF, '0, '0);
		issue(CMD_GET_ID, 24'h000001, '0, '0);                    // absent id
		issue(CMD_STORE, 24'h000000, 32'h8040_2010, 32'h0000_0005); // update in place
		issue(CMD_GET_ID, 24'h000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(CMD_COUNT, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// Random part. Disabling keeps the contents, which come back on re-enable.
		random_phase(1, 1, 500);
		random_phase(1, 0, 500);
		random_phase(0, 0, 150);
		random_phase(1, 0, 500);
		random_phase(1, 1, 100);
		random_phase(1, 0, 400);

		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.replies.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
